>>> design/pdlc_pkg.sv
package pdlc_pkg;

  localparam int PASSWORD_CHARS = 6;
  localparam int LEN_W = $clog2(PASSWORD_CHARS + 1);
  localparam int IDX_W = (PASSWORD_CHARS > 1) ? $clog2(PASSWORD_CHARS) : 1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [7:0] LOCK_TICKS_RST  = 8'd15;
  localparam logic [7:0] HOLD_TICKS_RST  = 8'd3;
  localparam logic [7:0] ALARM_TICKS_RST = 8'd60;
  localparam logic [2:0] MAX_ATTEMPTS_RST = 3'd3;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CFG_LOCK_TICKS   = 2'd0,
    CFG_HOLD_TICKS   = 2'd1,
    CFG_ALARM_TICKS  = 2'd2,
    CFG_MAX_ATTEMPTS = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    CODE_NEW      = 3'd0,
    CODE_ENTER    = 3'd1,
    CODE_OPENING  = 3'd2,
    CODE_LOCKING  = 3'd3,
    CODE_ALARM    = 3'd4,
    CODE_OPTIONS  = 3'd5,
    CODE_CONFIRM  = 3'd6
  } code_t;

  typedef enum logic [1:0] {
    MOTOR_IDLE = 2'd0,
    MOTOR_OPEN = 2'd1,
    MOTOR_LOCK = 2'd2
  } motor_t;

  typedef enum logic [3:0] {
    M_START        = 4'd0,
    M_NEW_FIRST    = 4'd1,
    M_NEW_CONFIRM  = 4'd2,
    M_OPTIONS      = 4'd3,
    M_OPEN_ENTER   = 4'd4,
    M_CHANGE_ENTER = 4'd5,
    M_OPENING      = 4'd6,
    M_HOLD         = 4'd7,
    M_LOCKING      = 4'd8,
    M_ALARM        = 4'd9
  } mode_t;

endpackage

>>> design/password_door_lock_controller.sv
// Lock controller behind a keypad terminal.
// Input stream (s_axis): tuser carries the request kind (start, received
// byte, one-second tick), tdata the received byte. Every word gives exactly
// one result word on m_axis: tuser is 1 when a prompt code is sent, tdata
// holds the prompt code, the motor drive and the buzzer drive.
// Configuration channel (cfg_*): index 0 lock period, 1 wait period,
// 2 alarm period, 3 max attempts; always ready; to be written only while idle (not enforced).
// Path: an accepted word enters the input register, is processed into the
// result register and its result is shown from then on.
// Throughput: one word per cycle while results are taken; the single-step
// state update between the input and result registers sets this figure.
// Reset: the controller waits for a start word, wrong-attempt and tick
// counters clear, the stored password is empty and the configuration
// returns to 15 / 3 / 60 / 3.
// Stall: when m_axis_tready is low the result register holds its word;
// one more input word is taken into the input register, then s_axis_tready
// drops until the result is taken.
module password_door_lock_controller
  import pdlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] tx_code, [4:3] motor_drive, [5] buzzer
  output logic       m_axis_tuser,   // [0] tx_valid
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_byte;
  logic       advance;

  logic [7:0] lock_ticks;
  logic [7:0] hold_ticks;
  logic [7:0] alarm_ticks;
  logic [2:0] max_attempts;

  mode_t      mode, mode_next;
  logic [2:0] wrong, wrong_next;
  logic [7:0] phase, phase_next;
  logic [7:0] entry_chars [PASSWORD_CHARS];
  logic [7:0] entry_chars_next [PASSWORD_CHARS];
  logic [LEN_W-1:0] entry_len, entry_len_next;
  logic       entry_ovf, entry_ovf_next;
  logic [7:0] first_chars [PASSWORD_CHARS];
  logic [LEN_W-1:0] first_len;
  logic       first_ovf;
  logic [7:0] stored_chars [PASSWORD_CHARS];
  logic [LEN_W-1:0] stored_len;
  logic       copy_first, copy_stored;

  logic       out_valid;
  logic       out_say;
  code_t      out_code;
  motor_t     out_motor;
  logic       out_buzzer;

  logic       say;
  code_t      said;
  motor_t     motor_next;
  logic [7:0] phase_inc;
  logic [2:0] wrong_inc;
  logic [2:0] limit;
  logic       match_first, match_stored;
  logic       eq_first, eq_stored;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_ticks   <= LOCK_TICKS_RST;
      hold_ticks   <= HOLD_TICKS_RST;
      alarm_ticks  <= ALARM_TICKS_RST;
      max_attempts <= MAX_ATTEMPTS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCK_TICKS:   lock_ticks   <= cfg_data;
        CFG_HOLD_TICKS:   hold_ticks   <= cfg_data;
        CFG_ALARM_TICKS:  alarm_ticks  <= cfg_data;
        CFG_MAX_ATTEMPTS: max_attempts <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  always_comb begin
    eq_first  = 1'b1;
    eq_stored = 1'b1;
    for (int i = 0; i < PASSWORD_CHARS; i++) begin
      if (LEN_W'(i) < entry_len) begin
        if (entry_chars[i] != first_chars[i]) eq_first = 1'b0;
        if (entry_chars[i] != stored_chars[i]) eq_stored = 1'b0;
      end
    end
  end

  assign match_first  = !entry_ovf && !first_ovf && (entry_len == first_len) && eq_first;
  assign match_stored = !entry_ovf && (entry_len == stored_len) && eq_stored;
  assign phase_inc    = (phase == 8'hFF) ? phase : phase + 8'd1;
  assign wrong_inc    = (wrong == 3'd7) ? wrong : wrong + 3'd1;
  assign limit        = (max_attempts == 3'd0) ? 3'd1 : max_attempts;

  always_comb begin
    mode_next        = mode;
    wrong_next       = wrong;
    phase_next       = phase;
    entry_chars_next = entry_chars;
    entry_len_next   = entry_len;
    entry_ovf_next   = entry_ovf;
    copy_first       = 1'b0;
    copy_stored      = 1'b0;
    say              = 1'b0;
    said             = CODE_NEW;
    case (in_req)
      REQ_START: begin
        if (mode == M_START) begin
          entry_len_next = '0;
          entry_ovf_next = 1'b0;
          mode_next      = M_NEW_FIRST;
          say            = 1'b1;
          said           = CODE_NEW;
        end
      end
      REQ_BYTE: begin
        case (mode)
          M_NEW_FIRST, M_NEW_CONFIRM, M_OPEN_ENTER, M_CHANGE_ENTER: begin
            if (in_byte == CH_HASH) begin
              entry_len_next = '0;
              entry_ovf_next = 1'b0;
              say            = 1'b1;
              case (mode)
                M_NEW_FIRST: begin
                  copy_first = 1'b1;
                  mode_next  = M_NEW_CONFIRM;
                  said       = CODE_CONFIRM;
                end
                M_NEW_CONFIRM: begin
                  if (match_first) begin
                    copy_stored = 1'b1;
                    mode_next   = M_OPTIONS;
                    said        = CODE_OPTIONS;
                  end else begin
                    mode_next = M_NEW_FIRST;
                    said      = CODE_NEW;
                  end
                end
                M_CHANGE_ENTER: begin
                  if (match_stored) begin
                    mode_next = M_NEW_FIRST;
                    said      = CODE_NEW;
                  end else begin
                    said = CODE_ENTER;
                  end
                end
                default: begin
                  if (match_stored) begin
                    wrong_next = '0;
                    phase_next = '0;
                    mode_next  = M_OPENING;
                    said       = CODE_OPENING;
                  end else if (wrong_inc >= limit) begin
                    wrong_next = '0;
                    phase_next = '0;
                    mode_next  = M_ALARM;
                    said       = CODE_ALARM;
                  end else begin
                    wrong_next = wrong_inc;
                    said       = CODE_ENTER;
                  end
                end
              endcase
            end else if (entry_len < LEN_W'(PASSWORD_CHARS)) begin
              entry_chars_next[entry_len[IDX_W-1:0]] = in_byte;
              entry_len_next = entry_len + LEN_W'(1);
            end else begin
              entry_ovf_next = 1'b1;
            end
          end
          M_OPTIONS: begin
            say = 1'b1;
            if (in_byte == CH_PLUS) begin
              entry_len_next = '0;
              entry_ovf_next = 1'b0;
              mode_next      = M_CHANGE_ENTER;
              said           = CODE_ENTER;
            end else if (in_byte == CH_MINUS) begin
              entry_len_next = '0;
              entry_ovf_next = 1'b0;
              wrong_next     = '0;
              mode_next      = M_OPEN_ENTER;
              said           = CODE_ENTER;
            end else begin
              said = CODE_OPTIONS;
            end
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        case (mode)
          M_OPENING: begin
            phase_next = phase_inc;
            if (phase_inc >= lock_ticks) begin
              phase_next = '0;
              if (hold_ticks == 8'd0) begin
                mode_next = M_LOCKING;
                say       = 1'b1;
                said      = CODE_LOCKING;
              end else begin
                mode_next = M_HOLD;
              end
            end
          end
          M_HOLD: begin
            phase_next = phase_inc;
            if (phase_inc >= hold_ticks) begin
              phase_next = '0;
              mode_next  = M_LOCKING;
              say        = 1'b1;
              said       = CODE_LOCKING;
            end
          end
          M_LOCKING: begin
            phase_next = phase_inc;
            if (phase_inc >= lock_ticks) begin
              phase_next = '0;
              mode_next  = M_OPTIONS;
              say        = 1'b1;
              said       = CODE_OPTIONS;
            end
          end
          M_ALARM: begin
            phase_next = phase_inc;
            if (phase_inc >= alarm_ticks) begin
              phase_next = '0;
              mode_next  = M_OPTIONS;
              say        = 1'b1;
              said       = CODE_OPTIONS;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_next)
      M_OPENING: motor_next = MOTOR_OPEN;
      M_LOCKING: motor_next = MOTOR_LOCK;
      default:   motor_next = MOTOR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_START;
      wrong      <= '0;
      phase      <= '0;
      entry_len  <= '0;
      entry_ovf  <= 1'b0;
      first_len  <= '0;
      first_ovf  <= 1'b0;
      stored_len <= '0;
    end else if (advance) begin
      mode      <= mode_next;
      wrong     <= wrong_next;
      phase     <= phase_next;
      entry_len <= entry_len_next;
      entry_ovf <= entry_ovf_next;
      if (copy_first) begin
        first_len <= entry_len;
        first_ovf <= entry_ovf;
      end
      if (copy_stored) begin
        stored_len <= entry_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_chars <= entry_chars_next;
      if (copy_first) first_chars <= entry_chars;
      if (copy_stored) stored_chars <= entry_chars;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_say    <= say;
      out_code   <= say ? said : CODE_NEW;
      out_motor  <= motor_next;
      out_buzzer <= (mode_next == M_ALARM);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_say;
  assign m_axis_tdata  = {2'b00, out_buzzer, out_motor, out_code};

endmodule

>>> design/pdlc_checker.sv
module pdlc_checker
  import pdlc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // result word never appears in the cycle right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result word right after reset");

  // motor and buzzer are never driven together, motor code is legal
  a_drive_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[4:3] != 2'd3) &&
                      (!m_axis_tdata[5] || m_axis_tdata[4:3] == MOTOR_IDLE))
    else $error("illegal drive combination");

  // no prompt means code zero; a prompt code is never out of range
  a_code_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || m_axis_tdata[2:0] == 3'd0) &&
                      (m_axis_tdata[2:0] != 3'd7) && (m_axis_tdata[7:6] == 2'b00))
    else $error("bad prompt code");

  // opening prompt only comes with the motor turning to open
  a_opening_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[2:0] == CODE_OPENING
      |-> m_axis_tdata[4:3] == MOTOR_OPEN)
    else $error("opening prompt without open drive");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

endmodule

bind password_door_lock_controller pdlc_checker u_pdlc_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import pdlc_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef logic [PASSWORD_CHARS-1:0][7:0] pw_t;

  typedef struct packed {
    logic   shown;
    code_t  code;
    motor_t motor;
    logic   buzz;
  } lock_out_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
  } key_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic [1:0] s_axis_tuser = 2'd0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;

  password_door_lock_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  key_word_t pending_keys [$];
  lock_out_t due_results [$];
  int        fails = 0;
  int        pushed = 0;
  int        in_gap = 0;
  int        out_stall = 0;
  logic      in_taken = 1'b0;
  logic      steady = 1'b0;

  // lock controller copy
  logic [7:0]       c_lock, c_wait, c_alarm;
  logic [2:0]       c_attempts;
  mode_t            p_mode;
  logic [2:0]       p_wrong;
  logic [7:0]       p_ticks;
  pw_t              p_entry, p_first, p_stored;
  logic [LEN_W-1:0] p_len, p_first_len, p_stored_len;
  logic             p_over, p_first_over;
  logic             p_say;
  code_t            p_code;

  function automatic void lock_reset();
    c_lock = LOCK_TICKS_RST;
    c_wait = HOLD_TICKS_RST;
    c_alarm = ALARM_TICKS_RST;
    c_attempts = MAX_ATTEMPTS_RST;
    p_mode = M_START;
    p_wrong = '0;
    p_ticks = '0;
    p_entry = '0;
    p_first = '0;
    p_stored = '0;
    p_len = '0;
    p_first_len = '0;
    p_stored_len = '0;
    p_over = 1'b0;
    p_first_over = 1'b0;
  endfunction

  function automatic void lock_config(logic [1:0] idx, logic [7:0] val);
    case (idx)
      CFG_LOCK_TICKS:   c_lock = val;
      CFG_HOLD_TICKS:   c_wait = val;
      CFG_ALARM_TICKS:  c_alarm = val;
      CFG_MAX_ATTEMPTS: c_attempts = val[2:0];
      default: ;
    endcase
  endfunction

  function automatic void prompt(code_t code);
    p_say = 1'b1;
    p_code = code;
  endfunction

  function automatic void clear_entry();
    p_len = '0;
    p_over = 1'b0;
  endfunction

  function automatic logic same_chars(pw_t a, pw_t b, logic [LEN_W-1:0] n);
    for (int i = 0; i < int'(n); i++)
      if (a[i] != b[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic entry_is_stored();
    return !p_over && p_len == p_stored_len && same_chars(p_entry, p_stored, p_len);
  endfunction

  function automatic logic tick_done(logic [7:0] period);
    if (p_ticks != 8'd255) p_ticks = p_ticks + 8'd1;
    return p_ticks >= period;
  endfunction

  function automatic void start_locking();
    p_ticks = '0;
    p_mode = M_LOCKING;
    prompt(CODE_LOCKING);
  endfunction

  function automatic void end_entry();
    logic [2:0] limit;
    case (p_mode)
      M_NEW_FIRST: begin
        p_first = p_entry;
        p_first_len = p_len;
        p_first_over = p_over;
        p_mode = M_NEW_CONFIRM;
        prompt(CODE_CONFIRM);
      end
      M_NEW_CONFIRM: begin
        if (!p_over && !p_first_over && p_len == p_first_len &&
            same_chars(p_entry, p_first, p_len)) begin
          p_stored = p_entry;
          p_stored_len = p_len;
          p_mode = M_OPTIONS;
          prompt(CODE_OPTIONS);
        end else begin
          p_mode = M_NEW_FIRST;
          prompt(CODE_NEW);
        end
      end
      M_CHANGE_ENTER: begin
        if (entry_is_stored()) begin
          p_mode = M_NEW_FIRST;
          prompt(CODE_NEW);
        end else begin
          prompt(CODE_ENTER);
        end
      end
      default: begin
        if (entry_is_stored()) begin
          p_wrong = '0;
          p_ticks = '0;
          p_mode = M_OPENING;
          prompt(CODE_OPENING);
        end else begin
          limit = (c_attempts == 3'd0) ? 3'd1 : c_attempts;
          if (p_wrong != 3'd7) p_wrong = p_wrong + 3'd1;
          if (p_wrong >= limit) begin
            p_wrong = '0;
            p_ticks = '0;
            p_mode = M_ALARM;
            prompt(CODE_ALARM);
          end else begin
            prompt(CODE_ENTER);
          end
        end
      end
    endcase
    clear_entry();
  endfunction

  function automatic void take_byte(logic [7:0] c);
    case (p_mode)
      M_NEW_FIRST, M_NEW_CONFIRM, M_OPEN_ENTER, M_CHANGE_ENTER: begin
        if (c == CH_HASH) begin
          end_entry();
        end else if (p_len < LEN_W'(PASSWORD_CHARS)) begin
          p_entry[p_len] = c;
          p_len = p_len + 1'b1;
        end else begin
          p_over = 1'b1;
        end
      end
      M_OPTIONS: begin
        if (c == CH_PLUS) begin
          clear_entry();
          p_mode = M_CHANGE_ENTER;
          prompt(CODE_ENTER);
        end else if (c == CH_MINUS) begin
          clear_entry();
          p_wrong = '0;
          p_mode = M_OPEN_ENTER;
          prompt(CODE_ENTER);
        end else begin
          prompt(CODE_OPTIONS);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_tick();
    case (p_mode)
      M_OPENING: begin
        if (tick_done(c_lock)) begin
          p_ticks = '0;
          if (c_wait == 8'd0) start_locking();
          else p_mode = M_HOLD;
        end
      end
      M_HOLD: if (tick_done(c_wait)) start_locking();
      M_LOCKING: begin
        if (tick_done(c_lock)) begin
          p_ticks = '0;
          p_mode = M_OPTIONS;
          prompt(CODE_OPTIONS);
        end
      end
      M_ALARM: begin
        if (tick_done(c_alarm)) begin
          p_ticks = '0;
          p_mode = M_OPTIONS;
          prompt(CODE_OPTIONS);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic lock_out_t lock_result(logic [1:0] req, logic [7:0] c);
    lock_out_t o;
    p_say = 1'b0;
    p_code = CODE_NEW;
    case (req)
      REQ_START: begin
        if (p_mode == M_START) begin
          clear_entry();
          p_mode = M_NEW_FIRST;
          prompt(CODE_NEW);
        end
      end
      REQ_BYTE: take_byte(c);
      REQ_TICK: take_tick();
      default: ;
    endcase
    o.shown = p_say;
    o.code = p_say ? p_code : CODE_NEW;
    o.motor = (p_mode == M_OPENING) ? MOTOR_OPEN :
              (p_mode == M_LOCKING) ? MOTOR_LOCK : MOTOR_IDLE;
    o.buzz = (p_mode == M_ALARM);
    return o;
  endfunction

  // stimulus helpers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_HASH) c = ~c;
    return c;
  endfunction

  function automatic void queue_key(logic [1:0] req, logic [7:0] data);
    key_word_t w;
    w.req = req;
    w.data = data;
    pending_keys.push_back(w);
    pushed++;
  endfunction

  function automatic void queue_entry(pw_t pw, int n);
    for (int i = 0; i < n; i++)
      queue_key(REQ_BYTE, (i < PASSWORD_CHARS) ? pw[i] : rand_char());
    queue_key(REQ_BYTE, CH_HASH);
  endfunction

  function automatic void fill_random(output pw_t pw, output int n);
    for (int i = 0; i < PASSWORD_CHARS; i++) pw[i] = rand_char();
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(PASSWORD_CHARS + 1, PASSWORD_CHARS + 3)
                                     : $urandom_range(0, PASSWORD_CHARS);
  endfunction

  function automatic void queue_wrong(pw_t pw, int n);
    pw_t        other;
    int         m, k;
    logic [7:0] orig;
    case ($urandom_range(0, 3))
      0: begin
        fill_random(other, m);
        queue_entry(other, m);
      end
      1: begin
        if (n > 0) begin
          k = $urandom_range(0, n - 1);
          orig = pw[k];
          do pw[k] = rand_char(); while (pw[k] == orig);
          queue_entry(pw, n);
        end else begin
          pw[0] = rand_char();
          queue_entry(pw, 1);
        end
      end
      2: begin
        if (n < PASSWORD_CHARS) pw[n] = rand_char();
        queue_entry(pw, n + 1);
      end
      default: queue_entry(pw, PASSWORD_CHARS + $urandom_range(1, 3));
    endcase
  endfunction

  // one well-formed step for the current controller mode, sometimes noise
  function automatic void queue_chunk();
    pw_t pw;
    int  n, r, k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 2))
        0: queue_key(REQ_RESERVED, 8'($urandom_range(0, 255)));
        1: queue_key(REQ_START, 8'($urandom_range(0, 255)));
        default: queue_key(REQ_TICK, 8'($urandom_range(0, 255)));
      endcase
      return;
    end
    case (p_mode)
      M_START: queue_key(REQ_START, 8'($urandom_range(0, 255)));
      M_NEW_FIRST: begin
        fill_random(pw, n);
        queue_entry(pw, n);
        if (r < 75) queue_entry(pw, n);
        else queue_wrong(pw, n);
      end
      M_NEW_CONFIRM: begin
        if (r < 70 && !p_first_over) queue_entry(p_first, int'(p_first_len));
        else queue_wrong(p_first, int'(p_first_len));
      end
      M_OPTIONS: begin
        k = $urandom_range(0, 99);
        if (k < 35) queue_key(REQ_BYTE, CH_PLUS);
        else if (k < 85) queue_key(REQ_BYTE, CH_MINUS);
        else queue_key(REQ_BYTE, rand_char());
      end
      M_OPEN_ENTER, M_CHANGE_ENTER: begin
        if (r < 65) queue_entry(p_stored, int'(p_stored_len));
        else queue_wrong(p_stored, int'(p_stored_len));
      end
      default: begin
        k = $urandom_range(1, 12);
        repeat (k) begin
          if ($urandom_range(0, 9) == 0) queue_key(REQ_BYTE, 8'($urandom_range(0, 255)));
          queue_key(REQ_TICK, 8'($urandom_range(0, 255)));
        end
      end
    endcase
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_keys.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: errors");
    $finish;
  end

  // sample results, record accepted words and register writes
  always @(posedge clk) begin : monitor
    lock_out_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing due: tuser %0d tdata %0h", m_axis_tuser,
                 m_axis_tdata);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tuser !== want.shown) begin
            $error("tx_valid: expected %0d, got %0d", want.shown, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[2:0] !== want.code) begin
            $error("tx_code: expected %0d, got %0d", want.code, m_axis_tdata[2:0]);
            fails++;
          end
          if (m_axis_tdata[4:3] !== want.motor) begin
            $error("motor_drive: expected %0d, got %0d", want.motor, m_axis_tdata[4:3]);
            fails++;
          end
          if (m_axis_tdata[5] !== want.buzz) begin
            $error("buzzer: expected %0d, got %0d", want.buzz, m_axis_tdata[5]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        due_results.push_back(lock_result(s_axis_tuser, s_axis_tdata));
      end
      if (cfg_valid && cfg_ready) lock_config(cfg_index, cfg_data);
    end
  end

  always @(negedge clk) begin : driver
    logic      drive;
    key_word_t w;
    drive = s_axis_tvalid && !in_taken;
    if (rst) begin
      drive = 1'b0;
    end else if (!drive) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_keys.size() != 0) begin
        w = pending_keys.pop_front();
        s_axis_tuser <= w.req;
        s_axis_tdata <= w.data;
        drive = 1'b1;
        in_gap = pick_gap();
      end
    end
    s_axis_tvalid <= drive;
  end

  always @(negedge clk) begin : sink
    logic rdy;
    if (out_stall > 0) begin
      rdy = 1'b0;
      out_stall--;
    end else begin
      rdy = 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
    m_axis_tready <= rdy;
  end

  initial begin
    pw_t        pw;
    int         phase, quota, base;
    logic [7:0] lp, wp, ap;
    logic [2:0] ma;
    lock_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // requests out of place, then a short password with extreme bytes
    queue_key(REQ_TICK, 8'h00);
    queue_key(REQ_BYTE, 8'h55);
    queue_key(REQ_RESERVED, 8'hFF);
    queue_key(REQ_START, 8'hFF);
    queue_key(REQ_START, 8'h00);
    pw = '0;
    pw[0] = 8'h00;
    pw[1] = 8'hFF;
    queue_entry(pw, 2);
    queue_entry(pw, 2);
    queue_key(REQ_BYTE, 8'h3F);
    queue_key(REQ_BYTE, CH_PLUS);
    queue_key(REQ_BYTE, CH_HASH);
    queue_entry(pw, 2);
    wait_idle();

    phase = 0;
    while (pushed < 450) begin
      case (phase)
        0: begin lp = 8'd0; wp = 8'd0; ap = 8'd0; ma = 3'd0; end
        1: begin lp = 8'd1; wp = 8'd0; ap = 8'd1; ma = 3'd1; end
        2: begin lp = 8'd255; wp = 8'd255; ap = 8'd255; ma = 3'd7; end
        default: begin
          lp = 8'($urandom_range(1, 4));
          wp = 8'($urandom_range(0, 3));
          ap = 8'($urandom_range(1, 6));
          ma = 3'($urandom_range(1, 4));
        end
      endcase
      quota = (phase == 2) ? 300 : 40;
      steady = (phase % 3 == 1);
      write_reg(CFG_LOCK_TICKS, lp);
      write_reg(CFG_HOLD_TICKS, wp);
      write_reg(CFG_ALARM_TICKS, ap);
      write_reg(CFG_MAX_ATTEMPTS, {5'd0, ma});
      base = pushed;
      while (pushed - base < quota) begin
        queue_chunk();
        wait_idle();
      end
      phase++;
    end

    wait_idle();
    if (fails == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
